@@ design/crc24st_pkg.sv @@
// Shared types, field widths, request codes and the CRC-24 byte fold for the slot table.
`timescale 1ns / 1ps
`default_nettype none

package crc24st_pkg;

    // Field widths fixed by the stream formats
    localparam int REQ_W        = 2;
    localparam int KEY_BYTE_W   = 8;
    localparam int DATA_W       = 32;
    localparam int SLOT_INDEX_W = 31;
    localparam int COUNT_W      = 9;
    localparam int SLOT_OUT_W   = 8;
    localparam int CFG_W        = 9;
    localparam int S_TDATA_W    = 72;
    localparam int S_TUSER_W    = 3;
    localparam int M_TDATA_W    = 56;

    // OpenPGP CRC-24
    localparam int              CRC_W    = 24;
    localparam logic [CRC_W-1:0] CRC_INIT = 24'hB704CE;
    localparam logic [CRC_W-1:0] CRC_POLY = 24'h864CFB;

    // Reset value of the slot count register
    localparam logic [CFG_W-1:0] CFG_RESET = 9'd8;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUT     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_GET     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_GET_IDX = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE    = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;         // a request is accepted this cycle
        logic fold_en;      // fold the key byte into the running CRC
        logic crc_reload;   // key finished: reload the CRC
        logic div_start;    // start the remainder unit
        logic div_use_idx;  // remainder of the slot index instead of the CRC
        logic mem_rd;       // read the addressed slot
        logic commit;       // write back a put and load the result register
        logic clr_wr;       // clearing pass: zero one slot
    } crc24st_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_last;     // clearing pass is at its final slot
        logic div_done;     // remainder unit idle, remainder valid
        logic out_free;     // result register can take a new result
    } crc24st_sts_t;

    // Fold one byte into the CRC, most significant bit first
    function automatic logic [CRC_W-1:0] crc24_fold(input logic [CRC_W-1:0] crc,
                                                    input logic [KEY_BYTE_W-1:0] data_byte);
        logic [CRC_W-1:0] c;
        c = crc ^ {data_byte, 16'h0000};
        for (int b = 0; b < 8; b++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ design/crc24st_mod.sv @@
// Bit-serial remainder unit: one dividend bit per cycle, restoring subtraction.
`timescale 1ns / 1ps
`default_nettype none

module crc24st_mod #(
    parameter int DVD_W = 31,
    parameter int N_W   = 9
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [N_W-1:0]   divisor,
    output logic                  done,
    output logic [N_W-1:0]        remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [N_W-1:0]   div_reg, div_next;
    logic [N_W-1:0]   rem_reg, rem_next;
    logic [N_W:0]     trial;
    logic [N_W:0]     diff;
    logic [N_W-1:0]   rem_step;

    // One restoring step: bring down the next bit and subtract if it fits
    always_comb begin
        trial = {rem_reg, dvd_reg[DVD_W-1]};
        diff  = trial - {1'b0, div_reg};
        if (trial >= {1'b0, div_reg}) begin
            rem_step = diff[N_W-1:0];
        end else begin
            rem_step = trial[N_W-1:0];
        end
    end

    // Load on start, then step until every dividend bit has been used
    always_comb begin
        cnt_next = cnt_reg;
        dvd_next = dvd_reg;
        div_next = div_reg;
        rem_next = rem_reg;
        if (start) begin
            cnt_next = CNT_W'(DVD_W);
            dvd_next = dividend;
            div_next = divisor;
            rem_next = '0;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - CNT_W'(1);
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            rem_next = rem_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = (cnt_reg == '0);
    assign remainder = rem_reg;

endmodule

`default_nettype wire

@@ design/crc24st_dp.sv @@
// Datapath: running CRC, remainder unit, slot memory, occupied count and result register.
`timescale 1ns / 1ps
`default_nettype none

module crc24st_dp #(
    parameter int MAX_SLOTS  = 256,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic [crc24st_pkg::CFG_W-1:0]          slots_in_use,
    input  wire logic [crc24st_pkg::REQ_W-1:0]          req_type,
    input  wire logic [crc24st_pkg::KEY_BYTE_W-1:0]     key_byte,
    input  wire logic                                   byte_valid,
    input  wire logic [crc24st_pkg::DATA_W-1:0]         put_value,
    input  wire logic [crc24st_pkg::SLOT_INDEX_W-1:0]   slot_index,
    input  wire crc24st_pkg::crc24st_cmd_t              cmd,
    output crc24st_pkg::crc24st_sts_t                   sts,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [crc24st_pkg::DATA_W-1:0]              read_value,
    output logic [crc24st_pkg::COUNT_W-1:0]             occupied_count,
    output logic [crc24st_pkg::SLOT_OUT_W-1:0]          chosen_slot
);

    import crc24st_pkg::*;

    localparam int AW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int N_W = $clog2(MAX_SLOTS + 1);
    localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'((MAX_SLOTS < 511) ? MAX_SLOTS : 511);
    localparam logic [AW-1:0]      LAST_ADDR = AW'(MAX_SLOTS - 1);

    logic [CRC_W-1:0]        crc_reg, crc_next;
    logic [CRC_W-1:0]        crc_folded;
    logic [CRC_W-1:0]        crc_cur;
    logic [31:0]             n_wide;
    logic [N_W-1:0]          n_sel;
    logic [SLOT_INDEX_W-1:0] dividend;
    logic                    div_done;
    logic [N_W-1:0]          rem;
    logic [AW-1:0]           slot_addr;
    logic [AW-1:0]           clr_addr_reg, clr_addr_next;
    logic                    is_put_reg, is_put_next;
    logic [VALUE_BITS+DATA_W-1:0] pv_ext;
    logic [VALUE_BITS-1:0]   put_val_reg, put_val_next;
    logic [VALUE_BITS-1:0]   mem [MAX_SLOTS];
    logic [VALUE_BITS-1:0]   rd_data_reg;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [VALUE_BITS-1:0]   mem_wdata;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [VALUE_BITS-1:0]   res_val;
    logic [VALUE_BITS+DATA_W-1:0] rv_ext;
    logic [AW+SLOT_OUT_W-1:0] slot_ext;
    logic                    out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]       out_val_reg, out_val_next;
    logic [COUNT_W-1:0]      out_cnt_reg, out_cnt_next;
    logic [SLOT_OUT_W-1:0]   out_slot_reg, out_slot_next;

    // Effective slot count: zero acts as one, large values are capped
    assign n_wide = {{(32 - CFG_W){1'b0}}, slots_in_use};
    always_comb begin
        if (n_wide == 32'd0) begin
            n_sel = N_W'(1);
        end else if (n_wide > 32'(MAX_SLOTS)) begin
            n_sel = N_W'(MAX_SLOTS);
        end else begin
            n_sel = n_wide[N_W-1:0];
        end
    end

    // Running CRC over the key bytes
    assign crc_folded = crc24_fold(crc_reg, key_byte);
    assign crc_cur    = byte_valid ? crc_folded : crc_reg;

    always_comb begin
        crc_next = crc_reg;
        if (cmd.crc_reload) begin
            crc_next = CRC_INIT;
        end else if (cmd.fold_en) begin
            crc_next = crc_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_INIT;
        end else begin
            crc_reg <= crc_next;
        end
    end

    // Slot number: remainder of the final CRC or of the slot index
    assign dividend = cmd.div_use_idx ? slot_index
                                      : {{(SLOT_INDEX_W - CRC_W){1'b0}}, crc_cur};

    crc24st_mod #(
        .DVD_W (SLOT_INDEX_W),
        .N_W   (N_W)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (dividend),
        .divisor   (n_sel),
        .done      (div_done),
        .remainder (rem)
    );

    assign slot_addr = rem[AW-1:0];

    // Request details kept while the slot number is worked out
    assign pv_ext = {{VALUE_BITS{1'b0}}, put_value};
    always_comb begin
        is_put_next  = is_put_reg;
        put_val_next = put_val_reg;
        if (cmd.take) begin
            is_put_next  = (req_type == REQ_PUT);
            put_val_next = pv_ext[VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        is_put_reg  <= is_put_next;
        put_val_reg <= put_val_next;
    end

    // Clearing pass address after reset
    always_comb begin
        clr_addr_next = clr_addr_reg;
        if (cmd.clr_wr) begin
            clr_addr_next = clr_addr_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else begin
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Slot memory: one write port, one registered read port
    assign mem_we    = cmd.clr_wr | (cmd.commit & is_put_reg);
    assign mem_waddr = cmd.clr_wr ? clr_addr_reg : slot_addr;
    assign mem_wdata = cmd.clr_wr ? '0 : put_val_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.mem_rd) begin
            rd_data_reg <= mem[slot_addr];
        end
    end

    // Occupied count: a put into an empty slot counts, up to the cap
    always_comb begin
        count_next = count_reg;
        if (cmd.commit && is_put_reg && (rd_data_reg == '0) && (count_reg < COUNT_CAP)) begin
            count_next = count_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Result register
    assign res_val  = is_put_reg ? put_val_reg : rd_data_reg;
    assign rv_ext   = {{DATA_W{1'b0}}, res_val};
    assign slot_ext = {{SLOT_OUT_W{1'b0}}, slot_addr};

    always_comb begin
        out_valid_next = out_valid_reg;
        out_val_next   = out_val_reg;
        out_cnt_next   = out_cnt_reg;
        out_slot_next  = out_slot_reg;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
            out_val_next   = rv_ext[DATA_W-1:0];
            out_cnt_next   = count_next;
            out_slot_next  = slot_ext[SLOT_OUT_W-1:0];
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_val_reg  <= out_val_next;
        out_cnt_reg  <= out_cnt_next;
        out_slot_reg <= out_slot_next;
    end

    assign m_tvalid       = out_valid_reg;
    assign read_value     = out_val_reg;
    assign occupied_count = out_cnt_reg;
    assign chosen_slot    = out_slot_reg;

    // Status back to the controller
    assign sts.clr_last = (clr_addr_reg == LAST_ADDR);
    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || m_tready;

`ifndef ASSERT_OFF
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!out_valid_reg || m_tready))
        else $error("result committed while the result register is still full");
    a_read_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_rd |-> div_done)
        else $error("slot read before the remainder is ready");
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> div_done)
        else $error("remainder unit restarted while busy");
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_CAP)
        else $error("occupied count above its cap");
    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not presented");
`endif

endmodule

`default_nettype wire

@@ design/crc24st_ctrl.sv @@
// Controller: clearing pass, request decode and sequencing of the slot access.
`timescale 1ns / 1ps
`default_nettype none

module crc24st_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [crc24st_pkg::REQ_W-1:0] req_type,
    input  wire logic                          key_last,
    input  wire crc24st_pkg::crc24st_sts_t     sts,
    output crc24st_pkg::crc24st_cmd_t          cmd
);

    import crc24st_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_RESP  = 2'd3;

    logic [1:0] state_reg, state_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take = 1'b1;
                    if (req_type inside {REQ_PUT, REQ_GET}) begin
                        cmd.fold_en = 1'b1;
                        if (key_last) begin
                            cmd.crc_reload = 1'b1;
                            cmd.div_start  = 1'b1;
                            state_next     = ST_DIV;
                        end
                    end else if (req_type == REQ_GET_IDX) begin
                        cmd.div_start   = 1'b1;
                        cmd.div_use_idx = 1'b1;
                        state_next      = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    cmd.mem_rd = 1'b1;
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ design/crc24_hashed_slot_table.sv @@
// Top level of the CRC-24 hashed slot table: stream ports, slot count register, wiring.
//
//   Channel   Direction  Handshake          Contents
//   cfg       in         cfg_wr_en          slot count register
//   s_        in         s_tvalid/s_tready  one key byte, or a get-by-index request
//   m_        out        m_tvalid/m_tready  slot value, occupied count, slot number
//
// A request that only folds a key byte keeps the controller idle; the next follows at once.
// A request with a result (last key byte or get by index) runs the bit-serial remainder unit
// over every dividend bit, then one memory read and one write-back.
// After reset a clearing pass zeroes every slot of the slot memory with s_tready low.
// A result waits in the output register; key bytes are still taken, and a further request
// with a result is taken but holds its write-back until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module crc24_hashed_slot_table #(
    parameter int MAX_SLOTS  = 256,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [crc24st_pkg::CFG_W-1:0]       cfg_wr_data,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // key_byte[7:0], put_value[39:8], slot_index[70:40], zero[71]
    input  wire logic [crc24st_pkg::S_TDATA_W-1:0]   s_tdata,
    // req_type[1:0], byte_valid[2]
    input  wire logic [crc24st_pkg::S_TUSER_W-1:0]   s_tuser,
    input  wire logic                                s_tlast,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // read_value[31:0], occupied_count[40:32], chosen_slot[48:41], zero[55:49]
    output logic [crc24st_pkg::M_TDATA_W-1:0]        m_tdata
);

    import crc24st_pkg::*;

    logic [CFG_W-1:0]        slots_in_use_reg, slots_in_use_next;
    crc24st_cmd_t            cmd;
    crc24st_sts_t            sts;
    logic [DATA_W-1:0]       read_value;
    logic [COUNT_W-1:0]      occupied_count;
    logic [SLOT_OUT_W-1:0]   chosen_slot;

    // Slot count register
    assign slots_in_use_next = cfg_wr_en ? cfg_wr_data : slots_in_use_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_in_use_reg <= CFG_RESET;
        end else begin
            slots_in_use_reg <= slots_in_use_next;
        end
    end

    crc24st_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_type (s_tuser[1:0]),
        .key_last (s_tlast),
        .sts      (sts),
        .cmd      (cmd)
    );

    crc24st_dp #(
        .MAX_SLOTS  (MAX_SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .slots_in_use   (slots_in_use_reg),
        .req_type       (s_tuser[1:0]),
        .key_byte       (s_tdata[7:0]),
        .byte_valid     (s_tuser[2]),
        .put_value      (s_tdata[39:8]),
        .slot_index     (s_tdata[70:40]),
        .cmd            (cmd),
        .sts            (sts),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .read_value     (read_value),
        .occupied_count (occupied_count),
        .chosen_slot    (chosen_slot)
    );

    // Pack the result fields, lowest field first
    assign m_tdata = {7'b0, chosen_slot, occupied_count, read_value};

endmodule

`default_nettype wire

@@ tb/crc24_hashed_slot_table_test.sv @@
// Self-checking testbench for the CRC-24 hashed slot table, with its own table predictor.
`timescale 1ns / 1ps

module crc24_hashed_slot_table_test;

    import crc24st_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int TABLE_SLOTS    = 256;
    localparam int COUNT_CAP      = (TABLE_SLOTS < 511) ? TABLE_SLOTS : 511;
    localparam int RESULT_LATENCY = 40;
    localparam int MAX_SHOWN      = 10;
    localparam int KEY_POOL       = 8;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 60;
    localparam int FILL_CEILING   = 125;
    localparam int N_DIRECTED     = 25;
    localparam int TIMEOUT_NS     = 2_000_000;

    // One request on the input channel.
    typedef struct packed {
        logic [REQ_W-1:0]        kind;
        logic [KEY_BYTE_W-1:0]   key_byte;
        logic                    byte_valid;
        logic                    key_last;
        logic [DATA_W-1:0]       put_value;
        logic [SLOT_INDEX_W-1:0] slot_index;
    } slot_req_t;

    // One reply on the result channel.
    typedef struct packed {
        logic [DATA_W-1:0]     value;
        logic [COUNT_W-1:0]    count;
        logic [SLOT_OUT_W-1:0] slot;
    } slot_reply_t;

    typedef struct packed {
        slot_req_t   item;
        logic        typed;
        slot_reply_t reply;
    } directed_row_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic [S_TUSER_W-1:0] s_tuser     = '0;
    logic                 s_tlast     = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Predictor state: running hash, table contents, occupancy and slot count.
    logic [CRC_W-1:0]   hash_crc = CRC_INIT;
    logic [DATA_W-1:0]  slot_mem [TABLE_SLOTS] = '{default: '0};
    logic [COUNT_W-1:0] occupied = '0;
    logic [CFG_W-1:0]   slot_count_cfg = CFG_RESET;

    slot_reply_t expected_replies[$];
    slot_reply_t seen_reply;
    slot_reply_t want_reply;
    int          fault_count = 0;
    int          sender_idle_pct = 34;
    int          receiver_idle_pct = 47;

    logic [31:0] pool_bytes [KEY_POOL];
    int          pool_len [KEY_POOL];
    logic [CFG_W-1:0] phase_cfg [PHASES] = '{9'd1, 9'd256, 9'd13, 9'd511, 9'd8, 9'd0};

    // Directed requests at the reset slot count of eight. The empty key hashes to
    // B704CE, which lands in slot six.
    directed_row_t directed_rows [N_DIRECTED] = '{
        // Table is empty after reset: lowest and highest index.
        '{'{REQ_GET_IDX, 8'h00, 1'b0, 1'b0, 32'h00000000, 31'h00000000}, 1'b1,
          '{32'h00000000, 9'd0, 8'd0}},
        '{'{REQ_GET_IDX, 8'hFF, 1'b1, 1'b1, 32'hFFFFFFFF, 31'h7FFFFFFF}, 1'b1,
          '{32'h00000000, 9'd0, 8'd7}},
        // Empty key: get, put of all ones, read back by index.
        '{'{REQ_GET, 8'h00, 1'b0, 1'b1, 32'h00000000, 31'h0}, 1'b1, '{32'h0, 9'd0, 8'd6}},
        '{'{REQ_PUT, 8'h00, 1'b0, 1'b1, 32'hFFFFFFFF, 31'h0}, 1'b1,
          '{32'hFFFFFFFF, 9'd1, 8'd6}},
        '{'{REQ_GET_IDX, 8'h00, 1'b0, 1'b0, 32'h0, 31'd6}, 1'b1, '{32'hFFFFFFFF, 9'd1, 8'd6}},
        // Put of zero empties the slot, so the next nonzero put counts again.
        '{'{REQ_PUT, 8'h00, 1'b0, 1'b1, 32'h00000000, 31'h0}, 1'b1, '{32'h0, 9'd1, 8'd6}},
        '{'{REQ_PUT, 8'h00, 1'b0, 1'b1, 32'h00000001, 31'h0}, 1'b1, '{32'h1, 9'd2, 8'd6}},
        // Request type three with every field set is ignored.
        '{'{REQ_NONE, 8'hFF, 1'b1, 1'b1, 32'hFFFFFFFF, 31'h7FFFFFFF}, 1'b0, '0},
        // Three-byte key with a zero byte, interrupted by an index get and an ignored request.
        '{'{REQ_PUT, 8'h00, 1'b1, 1'b0, 32'h12345678, 31'h0}, 1'b0, '0},
        '{'{REQ_PUT, 8'hFF, 1'b1, 1'b0, 32'h0, 31'h0}, 1'b0, '0},
        '{'{REQ_GET_IDX, 8'hAA, 1'b1, 1'b1, 32'h0, 31'd5}, 1'b1, '{32'h0, 9'd2, 8'd5}},
        '{'{REQ_NONE, 8'h55, 1'b1, 1'b0, 32'h0, 31'h0}, 1'b0, '0},
        '{'{REQ_PUT, 8'h80, 1'b1, 1'b1, 32'hA5A5A5A5, 31'h0}, 1'b0, '0},
        // Same key again as a get; the invalid byte must not be folded.
        '{'{REQ_GET, 8'h00, 1'b1, 1'b0, 32'h0, 31'h0}, 1'b0, '0},
        '{'{REQ_GET, 8'hFF, 1'b1, 1'b0, 32'h0, 31'h0}, 1'b0, '0},
        '{'{REQ_GET, 8'h80, 1'b1, 1'b1, 32'h0, 31'h0}, 1'b0, '0},
        '{'{REQ_GET, 8'h00, 1'b0, 1'b0, 32'h0, 31'h0}, 1'b0, '0},
        '{'{REQ_GET, 8'h31, 1'b1, 1'b1, 32'h0, 31'h0}, 1'b0, '0},
        // Key closed by an empty last request, then read as a one-byte key.
        '{'{REQ_PUT, 8'h5A, 1'b1, 1'b0, 32'hDEADBEEF, 31'h0}, 1'b0, '0},
        '{'{REQ_PUT, 8'hC3, 1'b0, 1'b1, 32'h5A5A5A5A, 31'h0}, 1'b0, '0},
        '{'{REQ_GET, 8'h5A, 1'b1, 1'b1, 32'h0, 31'h0}, 1'b0, '0},
        // Large indices reduced by the slot count.
        '{'{REQ_GET_IDX, 8'h00, 1'b0, 1'b0, 32'h0, 31'h40000000}, 1'b0, '0},
        '{'{REQ_GET_IDX, 8'h00, 1'b0, 1'b0, 32'h0, 31'h2AAAAAAA}, 1'b0, '0},
        '{'{REQ_GET_IDX, 8'h00, 1'b0, 1'b0, 32'h0, 31'h55555555}, 1'b0, '0},
        '{'{REQ_PUT, 8'h00, 1'b0, 1'b1, 32'h80000000, 31'h0}, 1'b0, '0}
    };

    crc24_hashed_slot_table #(
        .MAX_SLOTS (TABLE_SLOTS),
        .VALUE_BITS(DATA_W)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Fold one key byte into the hash, most significant bit first.
    function automatic logic [CRC_W-1:0] fold_key_byte(input logic [CRC_W-1:0] crc,
                                                       input logic [KEY_BYTE_W-1:0] kb);
        logic [CRC_W:0] acc;
        acc = {1'b0, crc ^ {kb, 16'h0000}};
        for (int b = 0; b < 8; b++) begin
            acc = {acc[CRC_W-1:0], 1'b0};
            if (acc[CRC_W]) begin
                acc = acc ^ {1'b1, CRC_POLY};
            end
        end
        return acc[CRC_W-1:0];
    endfunction

    // Apply one accepted request to the predicted table; returns 1 when it yields a reply.
    function automatic bit predict_reply(input slot_req_t r, output slot_reply_t rep);
        logic [CFG_W-1:0]        n;
        logic [SLOT_INDEX_W-1:0] rem;
        logic [SLOT_OUT_W-1:0]   slot;
        rep = '0;
        n = slot_count_cfg;
        if (n == 0) begin
            n = 9'd1;
        end else if (n > TABLE_SLOTS) begin
            n = 9'(TABLE_SLOTS);
        end
        if (r.kind == REQ_NONE) begin
            return 1'b0;
        end
        if (r.kind == REQ_GET_IDX) begin
            rem = r.slot_index % SLOT_INDEX_W'(n);
            slot = rem[SLOT_OUT_W-1:0];
        end else begin
            if (r.byte_valid) begin
                hash_crc = fold_key_byte(hash_crc, r.key_byte);
            end
            if (!r.key_last) begin
                return 1'b0;
            end
            rem = SLOT_INDEX_W'(hash_crc % CRC_W'(n));
            slot = rem[SLOT_OUT_W-1:0];
            hash_crc = CRC_INIT;
            if (r.kind == REQ_PUT) begin
                if (slot_mem[slot] == '0 && occupied < COUNT_CAP) begin
                    occupied = occupied + 1'b1;
                end
                slot_mem[slot] = r.put_value;
            end
        end
        rep = '{slot_mem[slot], occupied, slot};
        return 1'b1;
    endfunction

    task automatic report_fault(input string msg);
        if (fault_count < MAX_SHOWN) begin
            $display("%s", msg);
        end
        fault_count++;
    endtask

    // Offer one request, with random idle cycles before it, and predict at acceptance.
    task automatic send_request(input slot_req_t r, input bit typed, input slot_reply_t typed_reply);
        slot_reply_t predicted;
        bit          has_reply;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, r.slot_index, r.put_value, r.key_byte};
        s_tuser  <= {r.byte_valid, r.kind};
        s_tlast  <= r.key_last;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        has_reply = predict_reply(r, predicted);
        if (has_reply) begin
            expected_replies.push_back(typed ? typed_reply : predicted);
        end
    endtask

    task automatic send_plain(input slot_req_t r);
        send_request(r, 1'b0, '0);
    endtask

    function automatic slot_req_t random_index_req();
        slot_req_t r;
        r.kind       = REQ_GET_IDX;
        r.key_byte   = KEY_BYTE_W'($urandom);
        r.byte_valid = 1'($urandom);
        r.key_last   = 1'($urandom);
        r.put_value  = $urandom;
        if ($urandom_range(1) == 0) begin
            r.slot_index = SLOT_INDEX_W'($urandom_range(600));
        end else begin
            r.slot_index = SLOT_INDEX_W'($urandom);
        end
        return r;
    endfunction

    function automatic slot_req_t random_ignored_req();
        slot_req_t r;
        r = random_index_req();
        r.kind = REQ_NONE;
        return r;
    endfunction

    // Change the slot count once every reply is in and the block has settled.
    task automatic write_slot_count(input logic [CFG_W-1:0] v);
        while (expected_replies.size() != 0) begin
            @(posedge aclk);
        end
        repeat (RESULT_LATENCY) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en      <= 1'b0;
        slot_count_cfg = v;
    endtask

    // Mostly whole keys drawn from a small pool, so gets meet earlier puts, mixed with
    // index gets, ignored requests and invalid bytes. In fill mode most keys are
    // empty-key puts, mostly of zero, which keeps emptying and refilling slots and pushes
    // the occupied count upwards.
    task automatic run_random_phase(input int budget, input bit fill_mode);
        int                 sent;
        int                 limit;
        int                 len;
        int                 pick;
        bit                 saturated;
        bit                 byte_end;
        logic [31:0]        kbytes;
        logic [DATA_W-1:0]  value;
        logic [REQ_W-1:0]   op;
        slot_req_t          r;
        sent      = 0;
        limit     = budget;
        saturated = 1'b0;
        while (sent < limit) begin
            if (!fill_mode && $urandom_range(99) < 20) begin
                send_plain(random_index_req());
                sent++;
            end else if ($urandom_range(99) < 5) begin
                send_plain(random_ignored_req());
            end else begin
                if (fill_mode) begin
                    len    = ($urandom_range(99) < 80) ? 0 : int'($urandom_range(1, 2));
                    kbytes = $urandom;
                    op     = ($urandom_range(9) != 0) ? REQ_PUT : REQ_GET;
                    value  = ($urandom_range(99) < 85) ? '0 : $urandom;
                end else begin
                    pick = int'($urandom_range(KEY_POOL - 1));
                    if ($urandom_range(99) < 15) begin
                        pool_len[pick]   = int'($urandom_range(4));
                        pool_bytes[pick] = $urandom;
                    end
                    len    = pool_len[pick];
                    kbytes = pool_bytes[pick];
                    op     = ($urandom_range(1) != 0) ? REQ_PUT : REQ_GET;
                    pick   = int'($urandom_range(99));
                    value  = (pick < 20) ? '0 : (pick < 30) ? '1 : $urandom;
                end
                byte_end = (len != 0) && ($urandom_range(1) != 0);
                for (int i = 0; i < len; i++) begin
                    // Occasional interruptions in the middle of a key.
                    if ($urandom_range(99) < 8) begin
                        r = ($urandom_range(1) != 0) ? random_index_req() : random_ignored_req();
                        send_plain(r);
                        if (r.kind != REQ_NONE) begin
                            sent++;
                        end
                    end
                    if ($urandom_range(99) < 5) begin
                        r            = random_index_req();
                        r.kind       = ($urandom_range(1) != 0) ? REQ_PUT : REQ_GET;
                        r.byte_valid = 1'b0;
                        r.key_last   = 1'b0;
                        send_plain(r);
                        sent++;
                    end
                    r            = random_index_req();
                    r.key_byte   = kbytes[8*i +: 8];
                    r.byte_valid = 1'b1;
                    r.key_last   = byte_end && (i == len - 1);
                    if (r.key_last) begin
                        r.kind      = op;
                        r.put_value = value;
                    end else begin
                        r.kind = ($urandom_range(1) != 0) ? REQ_PUT : REQ_GET;
                    end
                    send_plain(r);
                    sent++;
                end
                if (!byte_end) begin
                    r            = random_index_req();
                    r.kind       = op;
                    r.byte_valid = 1'b0;
                    r.key_last   = 1'b1;
                    r.put_value  = value;
                    send_plain(r);
                    sent++;
                end
            end
            if (fill_mode && !saturated && occupied == COUNT_CAP) begin
                saturated = 1'b1;
                limit     = sent + 20;
            end
        end
        s_tvalid <= 1'b0;
    endtask

    // Receiver back-pressure.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Compare every accepted reply with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_reply = '{m_tdata[31:0], m_tdata[40:32], m_tdata[48:41]};
            if (expected_replies.size() == 0) begin
                report_fault($sformatf("unexpected reply: value %h count %0d slot %0d",
                                       seen_reply.value, seen_reply.count, seen_reply.slot));
            end else begin
                want_reply = expected_replies.pop_front();
                if (seen_reply.value !== want_reply.value || seen_reply.count !== want_reply.count
                        || seen_reply.slot !== want_reply.slot) begin
                    report_fault($sformatf({"reply mismatch: expected value %h count %0d slot %0d,",
                                            " got value %h count %0d slot %0d"},
                                           want_reply.value, want_reply.count, want_reply.slot,
                                           seen_reply.value, seen_reply.count, seen_reply.slot));
                end
            end
        end
    end

    // Stimulus: reset, directed table, then random phases over several slot counts.
    initial begin
        for (int k = 0; k < KEY_POOL; k++) begin
            pool_len[k]   = int'($urandom_range(4));
            pool_bytes[k] = $urandom;
        end
        phase_cfg[4] = CFG_W'($urandom_range(2, 255));
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int k = 0; k < N_DIRECTED; k++) begin
            send_request(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].reply);
        end
        s_tvalid <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            case (p / 2)
                0: begin
                    sender_idle_pct   = 34;
                    receiver_idle_pct = 47;
                end
                1: begin
                    sender_idle_pct   = 47;
                    receiver_idle_pct = 34;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            write_slot_count(phase_cfg[p]);
            if (p == PHASES - 1) begin
                run_random_phase(FILL_CEILING, 1'b1);
            end else begin
                run_random_phase(PHASE_ITEMS, 1'b0);
            end
        end

        // Drain, then allow the block to settle before the verdict.
        while (expected_replies.size() != 0) begin
            @(posedge aclk);
        end
        repeat (RESULT_LATENCY) @(posedge aclk);
        if (fault_count == 0 && expected_replies.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
design/crc24st_pkg.sv
design/crc24st_mod.sv
design/crc24st_dp.sv
design/crc24st_ctrl.sv
design/crc24_hashed_slot_table.sv
tb/crc24_hashed_slot_table_test.sv
